// ===== design/assert_macros.svh =====
// Assertion macros shared by the pair viscosity accumulator RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define SPVA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SPVA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/spva_pkg.sv =====
// Shared types, constants and saturation helpers for the pair viscosity accumulator.
// No dependencies; imported by spva_iter_unit and the top level.
package spva_pkg;

	localparam int MAX_PARTICLES = 1024;
	localparam int DIMENSIONS    = 2;
	localparam int IDX_W         = $clog2(MAX_PARTICLES);
	localparam int DIM_W         = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
	localparam int Q_W           = 32;
	localparam int VEC_W         = 64;
	localparam int ACC_W         = 48;
	localparam int APB_AW        = 4;
	localparam int AU_N_W        = 64;
	localparam int AU_D_W        = 33;
	localparam int AU_REM_W      = 36;
	localparam int AU_CNT_W      = 7;
	localparam int DIV_STEPS     = 64;
	localparam int SQRT_STEPS    = 32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_PAIR  = 2'd1;
	localparam logic [1:0] OP_DRAIN = 2'd2;

	localparam logic [1:0] REG_FLUID  = 2'd0;
	localparam logic [1:0] REG_SECOND = 2'd1;
	localparam logic [1:0] REG_SLIP   = 2'd2;

	localparam logic [2:0] CLS_IGNORED = 3'd0;
	localparam logic [2:0] CLS_FLUID   = 3'd1;
	localparam logic [2:0] CLS_SECOND  = 3'd2;
	localparam logic [2:0] CLS_WALL    = 3'd3;
	localparam logic [2:0] CLS_MIRROR  = 3'd4;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [5:0] {
		ST_CLEAR, ST_IDLE, ST_LOAD,
		PR_CHECK, PR_NU, PR_NU_W, PR_SQ_M, PR_SQ_A, PR_SQRT, PR_SQRT_W,
		PR_DW_M, PR_DW_D, PR_DW_W, PR_RT_D, PR_RT_W, PR_RT_M, PR_RT_A,
		PR_SN_M, PR_SN_A, PR_B_M, PR_B_A, PR_T_D, PR_T_W, PR_I_M, PR_I_A,
		PR_ACC_I, PR_ACC_JR, PR_ACC_J,
		DR_RD, DR_D, DR_W, DR_CLR, DR_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic sqrt;
	} au_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} au_stat_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] ci;
		logic [2:0] cj;
	} cls_t;

	function automatic cls_t type_decode(logic [4:0] tp);
		cls_t       c;
		logic [4:0] base;
		c.ok = 1'b1;
		if (tp < 5'd5) c.ci = 3'd0;
		else if (tp < 5'd10) c.ci = 3'd1;
		else if (tp < 5'd15) c.ci = 3'd2;
		else if (tp < 5'd20) c.ci = 3'd3;
		else if (tp < 5'd25) c.ci = 3'd4;
		else begin
			c.ci = 3'd0;
			c.ok = 1'b0;
		end
		base = {c.ci, 2'b00} + {2'b00, c.ci};
		c.cj = 3'(tp - base);
		return c;
	endfunction

	function automatic logic signed [31:0] comp(logic [63:0] w, logic [DIM_W-1:0] l);
		return w[Q_W*int'(l) +: Q_W];
	endfunction

	function automatic logic [31:0] mag32(logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [31:0] usat32(logic [63:0] v);
		return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// Signed result from a magnitude and a sign, saturated to 32 bits.
	function automatic logic signed [31:0] div_sat(logic [63:0] q, logic mz, logic neg);
		if (mz) return 32'sd0;
		if (neg) begin
			if (q > 64'd2147483648) return Q_MIN;
			return $signed(32'(32'd0 - q[31:0]));
		end
		if (q > 64'd2147483647) return Q_MAX;
		return $signed(q[31:0]);
	endfunction

	function automatic logic signed [31:0] sat32w(logic signed [35:0] v);
		if (v > 36'sd2147483647) return Q_MAX;
		if (v < -36'sd2147483648) return Q_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] acc_add(logic signed [47:0] a, logic signed [47:0] d);
		logic signed [48:0] s;
		s = {a[47], a} + {d[47], d};
		if (s[48] != s[47]) return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		return s[47:0];
	endfunction

endpackage

// ===== design/spva_iter_unit.sv =====
// Shared iterative unit: radix-2 restoring divider (64 by 33 bits) and
// bit-pair integer square root of a 64-bit value. Depends on spva_pkg.
module spva_iter_unit import spva_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  au_req_t             req,
	input  logic [AU_N_W-1:0]   num,
	input  logic [AU_D_W-1:0]   den,
	output au_stat_t            stat,
	output logic [AU_N_W-1:0]   res
);

	logic [AU_CNT_W-1:0] cnt_q;
	logic                sqrt_q;
	logic                done_q;
	logic [AU_N_W-1:0]   num_q;
	logic [AU_D_W-1:0]   den_q;
	logic [AU_REM_W-1:0] rem_q;
	logic [AU_N_W-1:0]   quo_q;

	logic [AU_REM_W-1:0] div_sh, sq_sh, trial;
	logic                div_ge, sq_ge;

	always_comb begin
		div_sh = {rem_q[AU_REM_W-2:0], num_q[AU_N_W-1]};
		div_ge = div_sh >= AU_REM_W'(den_q);
		sq_sh  = {rem_q[AU_REM_W-3:0], num_q[AU_N_W-1 -: 2]};
		trial  = {quo_q[AU_REM_W-3:0], 2'b01};
		sq_ge  = sq_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sqrt_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= req.sqrt ? AU_CNT_W'(SQRT_STEPS) : AU_CNT_W'(DIV_STEPS);
				sqrt_q <= req.sqrt;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == AU_CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (sqrt_q) begin
				num_q <= {num_q[AU_N_W-3:0], 2'b00};
				rem_q <= sq_ge ? sq_sh - trial : sq_sh;
				quo_q <= {quo_q[AU_N_W-2:0], sq_ge};
			end else begin
				num_q <= {num_q[AU_N_W-2:0], 1'b0};
				rem_q <= div_ge ? div_sh - AU_REM_W'(den_q) : div_sh;
				quo_q <= {quo_q[AU_N_W-2:0], div_ge};
			end
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign res       = quo_q;

endmodule

// ===== design/sph_pair_viscosity_accumulator_unit.sv =====
// Top level of the two-phase pair viscosity accumulator: sequencer, multiplier,
// mass and accumulator memories, APB registers. Depends on spva_pkg,
// spva_iter_unit and assert_macros.svh.
//
//  channel   | handshake                      | beat carries
//  ----------+--------------------------------+------------------------------------------
//  item      | item_valid / item_ready        | opcode, indices, type_pair, vectors, densities, mass
//  result    | result_valid / result_ready    | particle_index, force_x, force_y
//  config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// After reset the accumulator memory is swept to zero, one entry a cycle;
// item_ready stays low during the sweep while register writes are taken as usual.
// Each division and the square root run on the one shared iterative unit. A drain
// result waits in the output register, so the next beat is accepted while it is still
// unclaimed; a second drain only stalls at its end if the earlier result is still held.
module sph_pair_viscosity_accumulator_unit import spva_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [APB_AW-1:0]       paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [1:0]              opcode,
	input  logic [IDX_W-1:0]        index_i,
	input  logic [IDX_W-1:0]        index_j,
	input  logic [4:0]              type_pair,
	input  logic [VEC_W-1:0]        rel_pos,
	input  logic [VEC_W-1:0]        vel_i,
	input  logic [VEC_W-1:0]        vel_j,
	input  logic [VEC_W-1:0]        avg_vel_i,
	input  logic [VEC_W-1:0]        kernel_grad,
	input  logic [31:0]             density_i,
	input  logic [31:0]             density_j,
	input  logic [31:0]             mass_value,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [IDX_W-1:0]        particle_index,
	output logic signed [31:0]      force_x,
	output logic signed [31:0]      force_y
);

	// Configuration registers.
	logic [31:0] nu_q, nua_q;
	logic        slip_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nu_q   <= 32'h0001_0000;
			nua_q  <= 32'h0001_0000;
			slip_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_FLUID:  nu_q   <= pwdata;
				REG_SECOND: nua_q  <= pwdata;
				REG_SLIP:   slip_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FLUID:  prdata = nu_q;
			REG_SECOND: prdata = nua_q;
			REG_SLIP:   prdata = {31'd0, slip_q};
			default:    prdata = 32'd0;
		endcase
	end

	// Sequencer state and the beat held for the duration of the work.
	state_t state_q, state_d;

	logic [IDX_W-1:0]  idx_i_q, idx_j_q, clr_q;
	logic [4:0]        tp_q;
	logic [VEC_W-1:0]  rel_pos_q, vel_i_q, vel_j_q, avg_vel_q, kgrad_q;
	logic [31:0]       dens_i_q, dens_j_q, mass_val_q;

	logic [DIM_W-1:0]  dim_q;
	logic              side_q;
	logic              mz_q, neg_q;
	logic [31:0]       nuij_q, mj_q, r_q, a_q;
	logic [63:0]       r2_q, mul_q;
	logic [32:0]       s_q;
	logic signed [31:0] dw_q, b_q, temp_q, fx_q, fy_q;
	logic signed [47:0] inc_x_q, inc_y_q;

	logic              res_valid_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic signed [31:0] res_fx_q, res_fy_q;

	// Memories: mass table and the packed {y, x} accumulator pair.
	logic [31:0]          mass_mem [MAX_PARTICLES];
	logic [2*ACC_W-1:0]   acc_mem  [MAX_PARTICLES];
	logic [31:0]          mass_rd_q;
	logic [2*ACC_W-1:0]   acc_rd_q;
	logic [IDX_W-1:0]     mass_raddr, acc_raddr, acc_waddr;
	logic                 acc_we, mass_we;
	logic [2*ACC_W-1:0]   acc_wdata;

	// Shared iterative unit.
	au_req_t          ar_req;
	au_stat_t         ar_stat;
	logic [AU_N_W-1:0] ar_num, ar_res;
	logic [AU_D_W-1:0] ar_den;

	spva_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.num    (ar_num),
		.den    (ar_den),
		.stat   (ar_stat),
		.res    (ar_res)
	);

	// Decoded pair attributes and per-dimension operands.
	cls_t               cls;
	logic               harmonic, partner_fluid, nu_div, last_dim, item_acc;
	logic [32:0]        nu_sum, den_mag, s_sat;
	logic signed [32:0] den_s;
	logic signed [31:0] dx, gk, vi, vj, av, dv;
	logic signed [35:0] diff_a, diff_m;
	logic signed [47:0] acc_l;
	logic [47:0]        acc_mag;
	logic [31:0]        m_sel, rho_sel, mul_a, mul_b;
	logic signed [31:0] q_div;
	logic               wait_step;

	assign item_acc = item_valid && item_ready;

	// High in the states that wait for the iterative unit to finish.
	assign wait_step = (state_q == PR_NU_W) || (state_q == PR_SQRT_W) || (state_q == PR_DW_W)
	                || (state_q == PR_RT_W) || (state_q == PR_T_W) || (state_q == DR_W);

	always_comb begin
		cls           = type_decode(tp_q);
		harmonic      = (cls.ci == CLS_FLUID && cls.cj == CLS_SECOND)
		             || (cls.ci == CLS_SECOND && cls.cj == CLS_FLUID);
		partner_fluid = (cls.cj == CLS_FLUID) || (cls.cj == CLS_SECOND);
		nu_sum        = {1'b0, nu_q} + {1'b0, nua_q};
		nu_div        = harmonic && (nu_sum != 33'd0);
		last_dim      = (dim_q == DIM_W'(DIMENSIONS - 1));

		dx = comp(rel_pos_q, dim_q);
		gk = comp(kgrad_q, dim_q);
		vi = comp(vel_i_q, dim_q);
		vj = comp(vel_j_q, dim_q);
		av = comp(avg_vel_q, dim_q);

		// The gradient divisor is dx + 1 LSB; it is zero only for dx = -1 LSB.
		den_s   = {dx[31], dx} + 33'sd1;
		den_mag = den_s[32] ? 33'(-den_s) : 33'(den_s);

		// Wall partners see a plain or mirrored velocity difference when slip rules apply.
		diff_a = {{4{vi[31]}}, vi} - {{4{vj[31]}}, vj};
		diff_m = {{4{vi[31]}}, vi}
		       - (({{4{vj[31]}}, vj} <<< 1) - {{4{av[31]}}, av});
		if (partner_fluid || (slip_q && cls.cj == CLS_WALL)) dv = sat32w(diff_a);
		else if (slip_q && cls.cj == CLS_MIRROR) dv = sat32w(diff_m);
		else dv = 32'sd0;

		acc_l   = acc_rd_q[ACC_W*int'(dim_q) +: ACC_W];
		acc_mag = acc_l[47] ? 48'(-acc_l) : 48'(acc_l);

		m_sel   = side_q ? mass_rd_q : mj_q;
		rho_sel = side_q ? dens_i_q : dens_j_q;
		s_sat   = {1'b0, usat32({31'd0, s_q})};
		q_div   = div_sat(ar_res, mz_q, neg_q);
	end

	// One 32 by 32 multiplier, operands chosen by the sequencer, product registered.
	always_comb begin
		case (state_q)
			PR_CHECK: begin
				mul_a = nu_q;
				mul_b = nua_q;
			end
			PR_SQ_M: begin
				mul_a = mag32(dx);
				mul_b = mag32(dx);
			end
			PR_DW_M: begin
				mul_a = mag32(gk);
				mul_b = r_q;
			end
			PR_RT_M: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			PR_SN_M: begin
				mul_a = s_sat[31:0];
				mul_b = nuij_q;
			end
			PR_B_M: begin
				mul_a = mag32(dw_q);
				mul_b = s_q[31:0];
			end
			PR_I_M: begin
				mul_a = mag32(temp_q);
				mul_b = mag32(dv);
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= {32'd0, mul_a} * {32'd0, mul_b};
	end

	// Requests to the iterative unit.
	always_comb begin
		ar_req.start = 1'b0;
		ar_req.sqrt  = 1'b0;
		ar_num       = mul_q;
		ar_den       = nu_sum;
		case (state_q)
			PR_NU: ar_req.start = nu_div;
			PR_SQRT: begin
				ar_req.start = 1'b1;
				ar_req.sqrt  = 1'b1;
				ar_num       = r2_q;
			end
			PR_DW_D: begin
				ar_req.start = 1'b1;
				ar_den       = den_mag;
			end
			PR_RT_D: begin
				ar_req.start = 1'b1;
				ar_num       = {16'd0, m_sel, 16'd0};
				ar_den       = {1'b0, rho_sel};
			end
			PR_T_D: begin
				ar_req.start = 1'b1;
				ar_num       = {16'd0, mag32(b_q), 16'd0};
				ar_den       = {1'b0, r_q} + 33'd1;
			end
			DR_D: begin
				ar_req.start = 1'b1;
				ar_num       = {acc_mag, 16'd0};
				ar_den       = {1'b0, mass_rd_q};
			end
			default: ;
		endcase
	end

	// Next state and memory controls.
	always_comb begin
		state_d    = state_q;
		item_ready = (state_q == ST_IDLE);
		mass_we    = (state_q == ST_LOAD);
		mass_raddr = (state_q == PR_CHECK) ? idx_j_q : idx_i_q;
		acc_raddr  = (state_q == PR_ACC_JR) ? idx_j_q : idx_i_q;
		acc_we     = 1'b0;
		acc_waddr  = idx_i_q;
		acc_wdata  = '0;
		case (state_q)
			ST_CLEAR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q;
				if (clr_q == IDX_W'(MAX_PARTICLES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) begin
					case (opcode)
						OP_LOAD:  state_d = ST_LOAD;
						OP_PAIR:  state_d = PR_CHECK;
						OP_DRAIN: state_d = DR_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD:  state_d = ST_IDLE;
			PR_CHECK: state_d = (!cls.ok || cls.ci == CLS_IGNORED) ? ST_IDLE : PR_NU;
			PR_NU:    state_d = nu_div ? PR_NU_W : PR_SQ_M;
			PR_NU_W:  if (ar_stat.done) state_d = PR_SQ_M;
			PR_SQ_M:  state_d = PR_SQ_A;
			PR_SQ_A:  state_d = last_dim ? PR_SQRT : PR_SQ_M;
			PR_SQRT:  state_d = PR_SQRT_W;
			PR_SQRT_W: if (ar_stat.done) state_d = PR_DW_M;
			PR_DW_M:  state_d = PR_DW_D;
			PR_DW_D:  state_d = PR_DW_W;
			PR_DW_W:  if (ar_stat.done) state_d = last_dim ? PR_RT_D : PR_DW_M;
			PR_RT_D:  state_d = PR_RT_W;
			PR_RT_W:  if (ar_stat.done) state_d = PR_RT_M;
			PR_RT_M:  state_d = PR_RT_A;
			PR_RT_A:  state_d = side_q ? PR_SN_M : PR_RT_D;
			PR_SN_M:  state_d = PR_SN_A;
			PR_SN_A:  state_d = PR_B_M;
			PR_B_M:   state_d = PR_B_A;
			PR_B_A:   state_d = PR_T_D;
			PR_T_D:   state_d = PR_T_W;
			PR_T_W:   if (ar_stat.done) state_d = PR_I_M;
			PR_I_M:   state_d = PR_I_A;
			PR_I_A:   state_d = last_dim ? PR_ACC_I : PR_I_M;
			PR_ACC_I: begin
				acc_we    = 1'b1;
				acc_wdata = {acc_add(acc_rd_q[2*ACC_W-1:ACC_W], inc_y_q),
				             acc_add(acc_rd_q[ACC_W-1:0], inc_x_q)};
				state_d   = partner_fluid ? PR_ACC_JR : ST_IDLE;
			end
			PR_ACC_JR: state_d = PR_ACC_J;
			PR_ACC_J: begin
				// Read after the write to particle i, so i equal to j sees both updates.
				acc_we    = 1'b1;
				acc_waddr = idx_j_q;
				acc_wdata = {acc_add(acc_rd_q[2*ACC_W-1:ACC_W], 48'(-inc_y_q)),
				             acc_add(acc_rd_q[ACC_W-1:0], 48'(-inc_x_q))};
				state_d   = ST_IDLE;
			end
			DR_RD:  state_d = DR_D;
			DR_D:   state_d = DR_W;
			DR_W:   if (ar_stat.done) state_d = last_dim ? DR_CLR : DR_D;
			DR_CLR: begin
				acc_we  = 1'b1;
				state_d = DR_OUT;
			end
			DR_OUT: if (!res_valid_q || result_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mass_we) mass_mem[idx_i_q] <= mass_val_q;
		mass_rd_q <= mass_mem[mass_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
		acc_rd_q <= acc_mem[acc_raddr];
	end

	// Datapath registers stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					idx_i_q    <= index_i;
					idx_j_q    <= index_j;
					tp_q       <= type_pair;
					rel_pos_q  <= rel_pos;
					vel_i_q    <= vel_i;
					vel_j_q    <= vel_j;
					avg_vel_q  <= avg_vel_i;
					kgrad_q    <= kernel_grad;
					dens_i_q   <= density_i;
					dens_j_q   <= density_j;
					mass_val_q <= mass_value;
				end
				dim_q  <= '0;
				side_q <= 1'b0;
			end
			PR_CHECK: begin
				r2_q    <= 64'd0;
				s_q     <= 33'd0;
				inc_x_q <= 48'sd0;
				inc_y_q <= 48'sd0;
			end
			PR_NU: begin
				mj_q <= mass_rd_q;
				if (!nu_div) begin
					if (harmonic) nuij_q <= 32'd0;
					else if (cls.ci == CLS_SECOND && cls.cj == CLS_SECOND) nuij_q <= nua_q;
					else nuij_q <= nu_q;
				end
			end
			PR_NU_W: if (ar_stat.done) nuij_q <= usat32({ar_res[62:0], 1'b0});
			PR_SQ_A: begin
				r2_q  <= r2_q + mul_q;
				dim_q <= last_dim ? '0 : dim_q + 1'b1;
			end
			PR_SQRT_W: begin
				if (ar_stat.done) begin
					r_q  <= ar_res[31:0];
					dw_q <= 32'sd0;
				end
			end
			PR_DW_D: begin
				mz_q  <= (mul_q == 64'd0);
				neg_q <= gk[31] ^ den_s[32];
			end
			PR_DW_W: begin
				if (ar_stat.done) begin
					dw_q  <= sat32w({{4{dw_q[31]}}, dw_q} + {{4{q_div[31]}}, q_div});
					dim_q <= last_dim ? '0 : dim_q + 1'b1;
				end
			end
			PR_RT_D: mz_q <= (m_sel == 32'd0);
			PR_RT_W: if (ar_stat.done) a_q <= mz_q ? 32'd0 : usat32(ar_res);
			PR_RT_A: begin
				s_q    <= s_q + {1'b0, usat32({16'd0, mul_q[63:16]})};
				side_q <= 1'b1;
			end
			PR_SN_A: s_q <= {1'b0, usat32({16'd0, mul_q[63:16]})};
			PR_B_A:  b_q <= div_sat({16'd0, mul_q[63:16]}, 1'b0, dw_q[31]);
			PR_T_D: begin
				mz_q  <= (b_q == 32'sd0);
				neg_q <= b_q[31];
			end
			PR_T_W: if (ar_stat.done) temp_q <= q_div;
			PR_I_A: begin
				if (dim_q == '0) begin
					inc_x_q <= (temp_q[31] ^ dv[31]) ? 48'(-$signed(mul_q[63:16]))
					                                 : $signed(mul_q[63:16]);
				end else begin
					inc_y_q <= (temp_q[31] ^ dv[31]) ? 48'(-$signed(mul_q[63:16]))
					                                 : $signed(mul_q[63:16]);
				end
				dim_q <= last_dim ? '0 : dim_q + 1'b1;
			end
			DR_RD: fy_q <= 32'sd0;
			DR_D: begin
				mz_q  <= (acc_l == 48'sd0);
				neg_q <= acc_l[47];
			end
			DR_W: begin
				if (ar_stat.done) begin
					if (dim_q == '0) fx_q <= q_div;
					else fy_q <= q_div;
					dim_q <= last_dim ? '0 : dim_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output register: a finished drain result waits here for the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == DR_OUT && (!res_valid_q || result_ready)) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DR_OUT && (!res_valid_q || result_ready)) begin
			res_idx_q <= idx_i_q;
			res_fx_q  <= fx_q;
			res_fy_q  <= fy_q;
		end
	end

	assign result_valid   = res_valid_q;
	assign particle_index = res_idx_q;
	assign force_x        = res_fx_q;
	assign force_y        = res_fy_q;

	`include "assert_macros.svh"

	`SPVA_ASSERT_ALWAYS(a_idle_no_acc_write, (state_q == ST_IDLE) |-> !acc_we, "accumulator written while idle")
	`SPVA_ASSERT(a_unit_start_free, ar_req.start |-> !ar_stat.busy, "iterative unit restarted while busy")
	`SPVA_ASSERT(a_result_from_drain, $rose(res_valid_q) |-> $past(state_q == DR_OUT), "result raised outside a drain")
	`SPVA_ASSERT(a_done_in_wait, ar_stat.done |-> wait_step, "unit finished outside a wait step")

endmodule
